@@ hw/rtl/vsb_pkg.sv @@
`default_nettype none

package vsb_pkg;

	// Coordinates and direction components are signed Q12.12.
	localparam int COORD_W = 24;
	// One exact product of two coordinates.
	localparam int PROD_W  = 2 * COORD_W;
	// Exact sum of three products; one extra bit covers the growth.
	localparam int SCORE_W = PROD_W + 1;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [PROD_W-1:0]  prod_t;
	typedef logic signed [SCORE_W-1:0] score_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
	} vec_t;

	typedef struct packed {
		logic signed [PROD_W-1:0] px;
		logic signed [PROD_W-1:0] py;
		logic signed [PROD_W-1:0] pz;
	} prod3_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] dir_x;
		logic signed [COORD_W-1:0] dir_y;
		logic signed [COORD_W-1:0] dir_z;
		logic signed [COORD_W-1:0] vertex_x;
		logic signed [COORD_W-1:0] vertex_y;
		logic signed [COORD_W-1:0] vertex_z;
		logic                      last;
	} vsb_in_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] support_x;
		logic signed [COORD_W-1:0] support_y;
		logic signed [COORD_W-1:0] support_z;
		logic signed [COORD_W-1:0] lower_x;
		logic signed [COORD_W-1:0] lower_y;
		logic signed [COORD_W-1:0] lower_z;
		logic signed [COORD_W-1:0] upper_x;
		logic signed [COORD_W-1:0] upper_y;
		logic signed [COORD_W-1:0] upper_z;
	} vsb_out_t;

endpackage

`default_nettype wire

@@ hw/rtl/vsb_mul3.sv @@
`default_nettype none

// Three parallel signed multipliers with a register on each product.
module vsb_mul3
	import vsb_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   en,
	input  wire vec_t   dir,
	input  wire vec_t   vtx,
	output prod3_t      prod_s2
);

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2.px <= dir.x * vtx.x;
			prod_s2.py <= dir.y * vtx.y;
			prod_s2.pz <= dir.z * vtx.z;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/vertex_support_and_bounds.sv @@
`default_nettype none

// Channel  | Direction | Handshake              | Payload
// ---------+-----------+------------------------+-----------------------------------
// in       | input     | in_valid / in_ready    | in_data   (direction, vertex, last)
// out      | output    | out_valid / out_ready  | out_data  (support point, bounds)
//
// One vertex transaction is accepted per cycle while in_ready is high. The vertex marked
// last passes through the input register and the product register, and then loads the
// running state and the result register together, which raises out_valid. The one-cycle
// rate is set by the tracking stage, which adds the three products and compares against
// the best score combinationally. Reset clears the pipeline valid bits, the run state
// and the result valid. While a result waits on out_ready, vertices that are not last
// keep flowing into the running state; only a last vertex holds in the product stage.

module vertex_support_and_bounds
	import vsb_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_ready,
	input  wire vsb_in_t in_data,
	output logic         out_valid,
	input  wire logic    out_ready,
	output vsb_out_t     out_data
);

	// Input side: run tracking and the direction latch.
	logic   start_q;      // next accepted vertex opens a new run
	vec_t   held_dir_q;
	vec_t   dir_eff;
	logic   in_fire;

	// Stage 1: registered vertex with the direction it is scored against.
	logic   v_s1;
	vec_t   dir_s1;
	vec_t   vtx_s1;
	logic   last_s1;
	logic   first_s1;

	// Stage 2: products plus the vertex carried alongside.
	logic   v_s2;
	vec_t   vtx_s2;
	logic   last_s2;
	logic   first_s2;
	prod3_t prod_s2;

	// Running state and result register.
	vec_t   best_pt_q;
	score_t best_score_q;
	vec_t   lower_q;
	vec_t   upper_q;
	logic   out_valid_q;
	vsb_out_t out_q;

	// Flow control.
	logic   out_free;
	logic   fire2;
	logic   take2;

	// Next values of the running state.
	score_t score;
	logic   better;
	vec_t   best_pt_d;
	score_t best_score_d;
	vec_t   lower_d;
	vec_t   upper_d;

	// A last vertex may only enter the tracking stage when the result register can
	// take the transaction; any other vertex always can.
	assign out_free = !out_valid_q || out_ready;
	assign fire2    = v_s2 && (!last_s2 || out_free);
	assign take2    = !v_s2 || fire2;
	assign in_ready = !v_s1 || take2;
	assign in_fire  = in_valid && in_ready;

	// The direction of the first vertex of a run is used directly, later vertices
	// use the latched copy.
	always_comb begin
		if (start_q) begin
			dir_eff.x = in_data.dir_x;
			dir_eff.y = in_data.dir_y;
			dir_eff.z = in_data.dir_z;
		end else begin
			dir_eff = held_dir_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q    <= 1'b1;
			held_dir_q <= '0;
		end else if (in_fire) begin
			start_q <= in_data.last;
			if (start_q) begin
				held_dir_q <= dir_eff;
			end
		end
	end

	// Stage 1 registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			dir_s1   <= dir_eff;
			vtx_s1.x <= in_data.vertex_x;
			vtx_s1.y <= in_data.vertex_y;
			vtx_s1.z <= in_data.vertex_z;
			last_s1  <= in_data.last;
			first_s1 <= start_q;
		end
	end

	// Stage 2: multiplies, and the side band that travels with them.
	vsb_mul3 u_mul3 (
		.clk     (clk),
		.en      (take2 && v_s1),
		.dir     (dir_s1),
		.vtx     (vtx_s1),
		.prod_s2 (prod_s2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (take2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take2 && v_s1) begin
			vtx_s2   <= vtx_s1;
			last_s2  <= last_s1;
			first_s2 <= first_s1;
		end
	end

	// Tracking: exact dot product, strict improvement keeps the earliest vertex on
	// a tie, and per-axis bounds. The first vertex of a run seeds everything.
	always_comb begin
		score = SCORE_W'(prod_s2.px) + SCORE_W'(prod_s2.py) + SCORE_W'(prod_s2.pz);
		better = score > best_score_q;
		if (first_s2) begin
			best_pt_d    = vtx_s2;
			best_score_d = score;
			lower_d      = vtx_s2;
			upper_d      = vtx_s2;
		end else begin
			best_pt_d    = better ? vtx_s2 : best_pt_q;
			best_score_d = better ? score : best_score_q;
			lower_d.x    = (vtx_s2.x < lower_q.x) ? vtx_s2.x : lower_q.x;
			lower_d.y    = (vtx_s2.y < lower_q.y) ? vtx_s2.y : lower_q.y;
			lower_d.z    = (vtx_s2.z < lower_q.z) ? vtx_s2.z : lower_q.z;
			upper_d.x    = (vtx_s2.x > upper_q.x) ? vtx_s2.x : upper_q.x;
			upper_d.y    = (vtx_s2.y > upper_q.y) ? vtx_s2.y : upper_q.y;
			upper_d.z    = (vtx_s2.z > upper_q.z) ? vtx_s2.z : upper_q.z;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_pt_q    <= '0;
			best_score_q <= '0;
			lower_q      <= '0;
			upper_q      <= '0;
		end else if (fire2) begin
			best_pt_q    <= best_pt_d;
			best_score_q <= best_score_d;
			lower_q      <= lower_d;
			upper_q      <= upper_d;
		end
	end

	// Result register: loaded when the last vertex of a run is tracked.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire2 && last_s2) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire2 && last_s2) begin
			out_q.support_x <= best_pt_d.x;
			out_q.support_y <= best_pt_d.y;
			out_q.support_z <= best_pt_d.z;
			out_q.lower_x   <= lower_d.x;
			out_q.lower_y   <= lower_d.y;
			out_q.lower_z   <= lower_d.z;
			out_q.upper_x   <= upper_d.x;
			out_q.upper_y   <= upper_d.y;
			out_q.upper_z   <= upper_d.z;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

@@ test/vsb_support_checker.sv @@
// Watches both channels of vertex_support_and_bounds, predicts the support point and
// bounds of every run from the accepted vertices, and compares each delivered result
// field by field against the oldest prediction.
module vsb_support_checker
	import vsb_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	input  wire logic     in_ready,
	input  wire vsb_in_t  in_data,
	input  wire logic     out_valid,
	input  wire logic     out_ready,
	input  wire vsb_out_t out_data,
	output int            fail_count,
	output int            owed_count,
	output int            vertex_count,
	output int            result_count
);

	vec_t     held_dir;
	vec_t     best_vtx;
	vec_t     low_corner;
	vec_t     high_corner;
	longint   best_dot;
	bit       run_open;
	vsb_out_t expected_bounds [$];
	vsb_out_t want;
	coord_t   want_f;
	coord_t   got_f;
	string    field_name [0:8];

	initial begin
		field_name[0] = "support_x";
		field_name[1] = "support_y";
		field_name[2] = "support_z";
		field_name[3] = "lower_x";
		field_name[4] = "lower_y";
		field_name[5] = "lower_z";
		field_name[6] = "upper_x";
		field_name[7] = "upper_y";
		field_name[8] = "upper_z";
	end

	// Folds one vertex into the running state; a last vertex closes the run and
	// queues the result it owes.
	task automatic track_vertex(input vsb_in_t v);
		vec_t     p;
		longint   dot;
		vsb_out_t r;
		p.x = v.vertex_x;
		p.y = v.vertex_y;
		p.z = v.vertex_z;
		if (!run_open) begin
			held_dir.x = v.dir_x;
			held_dir.y = v.dir_y;
			held_dir.z = v.dir_z;
		end
		// The exact score fits easily in 64 bits at this coordinate width.
		dot = longint'(held_dir.x) * longint'(p.x) + longint'(held_dir.y) * longint'(p.y)
			+ longint'(held_dir.z) * longint'(p.z);
		if (!run_open || dot > best_dot) begin
			best_dot = dot;
			best_vtx = p;
		end
		if (!run_open) begin
			low_corner  = p;
			high_corner = p;
		end else begin
			if (p.x < low_corner.x)  low_corner.x  = p.x;
			if (p.y < low_corner.y)  low_corner.y  = p.y;
			if (p.z < low_corner.z)  low_corner.z  = p.z;
			if (p.x > high_corner.x) high_corner.x = p.x;
			if (p.y > high_corner.y) high_corner.y = p.y;
			if (p.z > high_corner.z) high_corner.z = p.z;
		end
		run_open = 1'b1;
		if (v.last) begin
			r.support_x = best_vtx.x;
			r.support_y = best_vtx.y;
			r.support_z = best_vtx.z;
			r.lower_x   = low_corner.x;
			r.lower_y   = low_corner.y;
			r.lower_z   = low_corner.z;
			r.upper_x   = high_corner.x;
			r.upper_y   = high_corner.y;
			r.upper_z   = high_corner.z;
			expected_bounds.push_back(r);
			run_open = 1'b0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_open    = 1'b0;
			held_dir    = '0;
			best_vtx    = '0;
			low_corner  = '0;
			high_corner = '0;
			best_dot    = 0;
			expected_bounds.delete();
			owed_count  = 0;
		end else begin
			if (in_valid && in_ready) begin
				track_vertex(in_data);
				vertex_count++;
			end
			if (out_valid && out_ready) begin
				result_count++;
				if (expected_bounds.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("[%0t] result %0d arrived with none outstanding: %h",
							$time, result_count, out_data);
				end else begin
					want = expected_bounds.pop_front();
					for (int i = 0; i < 9; i++) begin
						want_f = want[(9 - i) * COORD_W - 1 -: COORD_W];
						got_f  = out_data[(9 - i) * COORD_W - 1 -: COORD_W];
						if (want_f != got_f) begin
							fail_count++;
							if (fail_count <= 10)
								$display("[%0t] result %0d %s: expected %0d, got %0d",
									$time, result_count, field_name[i], want_f, got_f);
						end
					end
				end
			end
			owed_count = expected_bounds.size();
		end
	end

endmodule

@@ test/vertex_support_and_bounds_tb.sv @@
// Top of the testbench: drives vertex transactions into the block, drains result
// transactions with random back-pressure, and reports the verdict. All prediction and
// comparison happens in vsb_support_checker, which sits beside the block.
module vertex_support_and_bounds_tb;
	import vsb_pkg::*;

	localparam int     ITEMS       = 1100;
	localparam int     CYCLE_LIMIT = 200000;
	// Long enough for the block to fill up and drop in_ready several times over.
	localparam int     HOLD_CYCLES = 300;
	localparam coord_t CMIN        = {1'b1, {(COORD_W - 1){1'b0}}};
	localparam coord_t CMAX        = {1'b0, {(COORD_W - 1){1'b1}}};

	// Every input starts at a known value; reset is held from time zero.
	logic     clk       = 1'b0;
	logic     arst_n    = 1'b0;
	logic     in_valid  = 1'b0;
	logic     in_ready;
	vsb_in_t  in_data   = '0;
	logic     out_valid;
	logic     out_ready = 1'b0;
	vsb_out_t out_data;

	int fail_count;
	int owed_count;
	int vertex_count;
	int result_count;

	// Idle controls shared by the sender and the receiver. The stimulus process
	// retunes the gap limits per phase and posts a request for the long stall.
	int in_gap_max    = 6;
	int out_gap_max   = 6;
	int hold_requests = 0;
	int hold_served   = 0;
	int sent          = 0;
	int cycle_count   = 0;

	vertex_support_and_bounds dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	vsb_support_checker watch (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.in_data      (in_data),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_data     (out_data),
		.fail_count   (fail_count),
		.owed_count   (owed_count),
		.vertex_count (vertex_count),
		.result_count (result_count)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// A hung handshake ends the run here instead of spinning forever.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles with %0d results outstanding",
				cycle_count, owed_count);
			$display("vertex_support_and_bounds_tb: done, errors");
			$finish;
		end
	end

	// Coordinate mix: the two extremes, values near zero, small multiples of one in
	// Q12.12 (which makes equal scores common), and the full range.
	function automatic coord_t rand_coord();
		case ($urandom_range(0, 7))
			0:       return CMIN;
			1:       return CMAX;
			2:       return coord_t'(int'($urandom_range(0, 16)) - 8);
			3:       return coord_t'((int'($urandom_range(0, 8)) - 4) * 4096);
			default: return coord_t'($urandom);
		endcase
	endfunction

	function automatic vsb_in_t make_vertex(coord_t dx, coord_t dy, coord_t dz,
			coord_t vx, coord_t vy, coord_t vz, logic is_last);
		vsb_in_t v;
		v.dir_x    = dx;
		v.dir_y    = dy;
		v.dir_z    = dz;
		v.vertex_x = vx;
		v.vertex_y = vy;
		v.vertex_z = vz;
		v.last     = is_last;
		return v;
	endfunction

	// Offers one vertex transaction after a random gap and returns on the falling edge
	// after it is taken. Valid is left high so that a zero gap keeps it asserted
	// back to back; the caller lowers it whenever the sender goes quiet.
	task automatic send_vertex(input vsb_in_t v);
		int gap;
		gap = $urandom_range(0, in_gap_max);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= v;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		sent++;
	endtask

	// One mesh run. Only the first vertex's direction counts, so later vertices carry
	// junk there. Repeated vertices and axis-aligned or zero directions make ties,
	// where the earliest vertex must stay the support point.
	task automatic send_run(input int len);
		coord_t  dx;
		coord_t  dy;
		coord_t  dz;
		vsb_in_t v;
		dx = '0;
		dy = '0;
		dz = '0;
		case ($urandom_range(0, 5))
			0: ;
			1: begin
				case ($urandom_range(0, 2))
					0: dx = rand_coord();
					1: dy = rand_coord();
					default: dz = rand_coord();
				endcase
			end
			default: begin
				dx = rand_coord();
				dy = rand_coord();
				dz = rand_coord();
			end
		endcase
		v = '0;
		for (int i = 0; i < len; i++) begin
			v.dir_x = (i == 0) ? dx : coord_t'($urandom);
			v.dir_y = (i == 0) ? dy : coord_t'($urandom);
			v.dir_z = (i == 0) ? dz : coord_t'($urandom);
			if (i == 0 || $urandom_range(0, 4) != 0) begin
				v.vertex_x = rand_coord();
				v.vertex_y = rand_coord();
				v.vertex_z = rand_coord();
			end
			v.last = (i == len - 1);
			send_vertex(v);
		end
	endtask

	// Receiver: a random stall before each result, plus the long hold-off whenever
	// the stimulus posts one. The hold is counted here, not by the sender.
	initial begin : receive
		int stall;
		@(negedge clk);
		forever begin
			if (hold_served < hold_requests) begin
				hold_served++;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			stall = $urandom_range(0, out_gap_max);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			@(negedge clk);
		end
	end

	initial begin : stimulus
		int next_phase_at;
		bit pressed;
		bit drained;
		next_phase_at = 0;
		pressed       = 1'b0;
		drained       = 1'b0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Single-vertex runs: the vertex is the support point and both corners.
		// The first gives the most negative score, the second the largest one.
		send_vertex(make_vertex(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, 1'b1));
		send_vertex(make_vertex(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, 1'b1));

		// Extreme direction across a short run; the last vertex wins.
		send_vertex(make_vertex(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 1'b0));
		send_vertex(make_vertex(CMAX, 0, CMAX, 0, 0, 0, 1'b0));
		send_vertex(make_vertex(0, 0, 0, CMIN, CMIN, CMIN, 1'b1));

		// Zero direction: all scores are zero, so the first vertex stays.
		send_vertex(make_vertex(0, 0, 0, 5, -3, 7, 1'b0));
		send_vertex(make_vertex(CMAX, CMAX, CMAX, CMAX, 0, CMIN, 1'b0));
		send_vertex(make_vertex(CMIN, 1, 1, -1, CMAX, 2, 1'b1));

		// Equal scores along x keep the earliest vertex; a lower score changes nothing.
		send_vertex(make_vertex(4096, 0, 0, 100, 1, 1, 1'b0));
		send_vertex(make_vertex(0, 0, 4096, 100, 2, 2, 1'b0));
		send_vertex(make_vertex(0, 4096, 0, 100, -5, 9, 1'b0));
		send_vertex(make_vertex(4096, 0, 0, 99, 0, 0, 1'b0));
		send_vertex(make_vertex(CMIN, CMAX, CMIN, 100, CMAX, CMIN, 1'b1));

		// Strictly better scores replace the support point; the tie in between does not.
		send_vertex(make_vertex(0, 0, -4096, 0, 0, 10, 1'b0));
		send_vertex(make_vertex(0, 0, 0, 3, 0, -10, 1'b0));
		send_vertex(make_vertex(0, 0, 0, 0, 0, -10, 1'b0));
		send_vertex(make_vertex(0, 0, 0, 1, 1, -11, 1'b1));

		// Bounds that reach both ends of every axis.
		send_vertex(make_vertex(1, 1, 1, CMIN, CMAX, 0, 1'b0));
		send_vertex(make_vertex(0, 0, 0, CMAX, CMIN, CMIN, 1'b0));
		send_vertex(make_vertex(0, 0, 0, 0, 0, CMAX, 1'b1));

		while (sent < ITEMS) begin
			// Each phase picks its own idle limits, so some phases run with no gaps.
			if (sent >= next_phase_at) begin
				in_gap_max    = ($urandom_range(0, 2) == 0) ? 0 : 6;
				out_gap_max   = ($urandom_range(0, 2) == 0) ? 0 : 6;
				next_phase_at = sent + 120;
			end
			// Output held off for a long stretch while the sender keeps offering short
			// runs back to back, so the block backs up and stalls its input.
			if (!pressed && sent >= 350) begin
				pressed    = 1'b1;
				in_gap_max = 0;
				hold_requests++;
				repeat (25) send_run($urandom_range(1, 3));
			end
			// Let everything drain before carrying on.
			if (!drained && sent >= 750) begin
				drained = 1'b1;
				in_valid <= 1'b0;
				wait (owed_count == 0);
				@(negedge clk);
			end
			if ($urandom_range(0, 9) == 0)
				send_run($urandom_range(9, 40));
			else
				send_run($urandom_range(1, 6));
		end
		in_valid <= 1'b0;

		wait (owed_count == 0);
		repeat (12) @(negedge clk);

		$display("Covered %0d vertices and %0d results: extreme, zero and axis-aligned", vertex_count,
			result_count);
		$display("directions, ties, single-vertex runs, a %0d-cycle output stall and a full drain.",
			HOLD_CYCLES);
		if (fail_count == 0 && owed_count == 0)
			$display("vertex_support_and_bounds_tb: done, clean");
		else
			$display("vertex_support_and_bounds_tb: done, errors");
		$finish;
	end

endmodule
